FILE: design/bencode_stream_tokenizer_assert.svh
// assertion macros used by the tokenizer top level
`ifndef BENCODE_STREAM_TOKENIZER_ASSERT_SVH
`define BENCODE_STREAM_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BST_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bst assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define BST_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bst assertion failed");

`endif

FILE: design/bst_pkg.sv
// types and constants of the bencode stream tokenizer
package bst_pkg;

    typedef enum logic [2:0] {
        MD_VALUE      = 3'd0,
        MD_INT_SIGN   = 3'd1,
        MD_INT_DIGITS = 3'd2,
        MD_STR_LEN    = 3'd3,
        MD_STR_DATA   = 3'd4,
        MD_DONE       = 3'd5
    } bst_mode_t;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STR_START = 3'd1,
        EV_STR_BYTE  = 3'd2,
        EV_INTEGER   = 3'd3,
        EV_LIST_OPEN = 3'd4,
        EV_DICT_OPEN = 3'd5,
        EV_CLOSE     = 3'd6
    } bst_event_t;

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_BAD_TYPE  = 4'd1,
        ERR_KEY_TYPE  = 4'd2,
        ERR_BAD_DIGIT = 4'd3,
        ERR_STRAY_END = 4'd4,
        ERR_NO_VALUE  = 4'd5,
        ERR_TOO_DEEP  = 4'd6,
        ERR_OVERFLOW  = 4'd7,
        ERR_TRUNCATED = 4'd8
    } bst_error_t;

    // ascii codes of the syntax bytes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;

    // magnitude limits, 68 bits wide to hold acc*10+d
    localparam logic [67:0] INT_POS_LIMIT = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] INT_NEG_LIMIT = 68'h0_8000_0000_0000_0000;

    typedef struct packed {
        bst_event_t  event_res;
        logic [63:0] value;
        logic [7:0]  data_byte;
        logic [4:0]  nesting;
        logic        is_key;
        logic        string_last;
        logic        value_complete;
        logic        end_flag;
        bst_error_t  error_code;
    } bst_result_t;

endpackage

FILE: design/bst_parser.sv
// parser state, container stack and per-byte result logic
module bst_parser #(
    parameter int MAX_DEPTH   = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    output logic                 emit,
    output bst_pkg::bst_result_t res
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam logic [67:0] LEN_LIMIT = (68'd1 << LENGTH_BITS) - 68'd1;

    bst_pkg::bst_mode_t       mode_reg, mode_next;
    logic [63:0]              acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic                     seen_reg, seen_next;
    logic [LENGTH_BITS-1:0]   left_reg, left_next;
    logic [LW-1:0]            level_reg, level_next;
    bst_pkg::bst_error_t      sticky_reg, sticky_next;
    logic                     done_reg, done_next;
    // top of stack kept in flops, entries below it in the array
    logic                     top_kind_reg, top_kind_next;
    logic                     top_want_reg, top_want_next;
    logic                     kind_mem [MAX_DEPTH];
    logic                     want_mem [MAX_DEPTH];

    logic                     push_we;
    logic [IW-1:0]            wr_idx;
    logic [IW-1:0]            rd_idx;
    logic [LW-1:0]            level_m1;
    logic [LW-1:0]            level_m2;
    logic [7:0]               dig_wide;
    logic [3:0]               digit;
    logic                     is_digit;
    logic [67:0]              acc_x10;
    logic [67:0]              int_limit;
    logic                     at_key;
    logic [LW+4:0]            level_wide;
    logic [LENGTH_BITS-1:0]   left_dec;

    assign level_m1 = level_reg - LW'(1);
    assign level_m2 = level_reg - LW'(2);
    assign wr_idx   = level_m1[IW-1:0];
    assign rd_idx   = level_m2[IW-1:0];
    assign dig_wide = in_byte - bst_pkg::CH_ZERO;
    assign digit    = dig_wide[3:0];
    assign is_digit = in_byte inside {[bst_pkg::CH_ZERO:bst_pkg::CH_NINE]};
    assign acc_x10  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1) + {64'd0, digit};
    assign int_limit = neg_reg ? bst_pkg::INT_NEG_LIMIT : bst_pkg::INT_POS_LIMIT;
    assign at_key   = (level_reg != '0) && top_kind_reg && top_want_reg;
    assign left_dec = (left_reg != '0) ? left_reg - LENGTH_BITS'(1) : left_reg;

    always_comb
    begin
        bst_pkg::bst_event_t ev;
        bst_pkg::bst_error_t err;
        logic [63:0]         val;
        logic [7:0]          db;
        logic                key;
        logic                last;
        logic                finish;

        ev            = bst_pkg::EV_NONE;
        err           = bst_pkg::ERR_OK;
        val           = '0;
        db            = '0;
        key           = 1'b0;
        last          = 1'b0;
        finish        = 1'b0;
        push_we       = 1'b0;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        seen_next     = seen_reg;
        left_next     = left_reg;
        level_next    = level_reg;
        sticky_next   = sticky_reg;
        done_next     = done_reg;
        top_kind_next = top_kind_reg;
        top_want_next = top_want_reg;

        if (step && sticky_reg == bst_pkg::ERR_OK && !done_reg)
        begin
            case (mode_reg)
                bst_pkg::MD_VALUE:
                begin
                    if (is_digit)
                    begin
                        acc_next  = {60'd0, digit};
                        seen_next = 1'b1;
                        mode_next = bst_pkg::MD_STR_LEN;
                    end
                    else if (in_byte == bst_pkg::CH_E)
                    begin
                        if (level_reg == '0)
                            err = bst_pkg::ERR_STRAY_END;
                        else if (top_kind_reg && !top_want_reg)
                            err = bst_pkg::ERR_NO_VALUE;
                        else
                        begin
                            // pop: parent entry becomes the new top
                            level_next    = level_m1;
                            top_kind_next = kind_mem[rd_idx];
                            top_want_next = want_mem[rd_idx];
                            ev            = bst_pkg::EV_CLOSE;
                            finish        = 1'b1;
                        end
                    end
                    else if (at_key)
                    begin
                        if (in_byte == bst_pkg::CH_I || in_byte == bst_pkg::CH_L ||
                            in_byte == bst_pkg::CH_D)
                            err = bst_pkg::ERR_KEY_TYPE;
                        else
                            err = bst_pkg::ERR_BAD_TYPE;
                    end
                    else if (in_byte == bst_pkg::CH_I)
                    begin
                        acc_next  = '0;
                        neg_next  = 1'b0;
                        seen_next = 1'b0;
                        mode_next = bst_pkg::MD_INT_SIGN;
                    end
                    else if (in_byte == bst_pkg::CH_L || in_byte == bst_pkg::CH_D)
                    begin
                        if (level_reg >= LW'(MAX_DEPTH))
                            err = bst_pkg::ERR_TOO_DEEP;
                        else
                        begin
                            push_we       = (level_reg != '0);
                            top_kind_next = (in_byte == bst_pkg::CH_D);
                            top_want_next = (in_byte == bst_pkg::CH_D);
                            level_next    = level_reg + LW'(1);
                            ev = (in_byte == bst_pkg::CH_D) ? bst_pkg::EV_DICT_OPEN
                                                            : bst_pkg::EV_LIST_OPEN;
                        end
                    end
                    else
                        err = bst_pkg::ERR_BAD_TYPE;
                end
                bst_pkg::MD_INT_SIGN:
                begin
                    if (in_byte == bst_pkg::CH_MINUS)
                    begin
                        neg_next  = 1'b1;
                        mode_next = bst_pkg::MD_INT_DIGITS;
                    end
                    else if (is_digit)
                    begin
                        acc_next  = {60'd0, digit};
                        seen_next = 1'b1;
                        mode_next = bst_pkg::MD_INT_DIGITS;
                    end
                    else
                        err = bst_pkg::ERR_BAD_DIGIT;
                end
                bst_pkg::MD_INT_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (seen_reg && acc_reg == '0)
                            err = bst_pkg::ERR_BAD_DIGIT;
                        else if (acc_x10 > int_limit)
                            err = bst_pkg::ERR_OVERFLOW;
                        else
                        begin
                            acc_next  = acc_x10[63:0];
                            seen_next = 1'b1;
                        end
                    end
                    else if (in_byte == bst_pkg::CH_E)
                    begin
                        if (!seen_reg || (neg_reg && acc_reg == '0))
                            err = bst_pkg::ERR_BAD_DIGIT;
                        else
                        begin
                            ev     = bst_pkg::EV_INTEGER;
                            val    = neg_reg ? 64'd0 - acc_reg : acc_reg;
                            finish = 1'b1;
                        end
                    end
                    else
                        err = bst_pkg::ERR_BAD_DIGIT;
                end
                bst_pkg::MD_STR_LEN:
                begin
                    if (is_digit)
                    begin
                        if (acc_reg == '0)
                            err = bst_pkg::ERR_BAD_DIGIT;
                        else if (acc_x10 > LEN_LIMIT)
                            err = bst_pkg::ERR_OVERFLOW;
                        else
                            acc_next = acc_x10[63:0];
                    end
                    else if (in_byte == bst_pkg::CH_COLON)
                    begin
                        ev  = bst_pkg::EV_STR_START;
                        val = acc_reg;
                        key = at_key;
                        if (acc_reg == '0)
                            finish = 1'b1;
                        else
                        begin
                            left_next = acc_reg[LENGTH_BITS-1:0];
                            mode_next = bst_pkg::MD_STR_DATA;
                        end
                    end
                    else
                        err = bst_pkg::ERR_BAD_DIGIT;
                end
                bst_pkg::MD_STR_DATA:
                begin
                    ev        = bst_pkg::EV_STR_BYTE;
                    db        = in_byte;
                    key       = at_key;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        last   = 1'b1;
                        finish = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // value finished: mark top level done or flip key/value turn
            if (finish)
            begin
                if (level_next == '0)
                begin
                    done_next = 1'b1;
                    mode_next = bst_pkg::MD_DONE;
                end
                else
                begin
                    if (top_kind_next)
                        top_want_next = !top_want_next;
                    mode_next = bst_pkg::MD_VALUE;
                end
            end

            if (err != bst_pkg::ERR_OK)
                sticky_next = err;
        end

        if (step && in_end && sticky_next == bst_pkg::ERR_OK && !done_next)
            sticky_next = bst_pkg::ERR_TRUNCATED;

        emit = step && (ev != bst_pkg::EV_NONE || err != bst_pkg::ERR_OK || in_end);

        level_wide         = {5'd0, level_next};
        res.event_res      = ev;
        res.value          = val;
        res.data_byte      = db;
        res.nesting        = level_wide[4:0];
        res.is_key         = key;
        res.string_last    = last;
        res.value_complete = done_next;
        res.end_flag       = in_end;
        res.error_code     = sticky_next;

        // message over: back to the reset state
        if (step && in_end)
        begin
            mode_next   = bst_pkg::MD_VALUE;
            acc_next    = '0;
            neg_next    = 1'b0;
            seen_next   = 1'b0;
            left_next   = '0;
            level_next  = '0;
            sticky_next = bst_pkg::ERR_OK;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bst_pkg::MD_VALUE;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            left_reg     <= '0;
            level_reg    <= '0;
            sticky_reg   <= bst_pkg::ERR_OK;
            done_reg     <= 1'b0;
            top_kind_reg <= 1'b0;
            top_want_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            neg_reg      <= neg_next;
            seen_reg     <= seen_next;
            left_reg     <= left_next;
            level_reg    <= level_next;
            sticky_reg   <= sticky_next;
            done_reg     <= done_next;
            top_kind_reg <= top_kind_next;
            top_want_reg <= top_want_next;
        end
    end

    // push the old top entry below the new one
    always_ff @(posedge clk)
    begin
        if (push_we)
        begin
            kind_mem[wr_idx] <= top_kind_reg;
            want_mem[wr_idx] <= top_want_reg;
        end
    end

endmodule

FILE: design/bencode_stream_tokenizer.sv
// top level of the streaming bencode tokenizer
//
//  channel  | dir | transfer carries
//  ---------+-----+-----------------------------------------------------------
//  s_axis   | in  | one message byte, tlast on the message's last byte
//  m_axis   | out | one token event: kind and key flag in tuser, rest in tdata
//
// one byte per cycle sustained while m_axis does not stall; a byte's result
// passes the input register, then the parser logic into the result register
// bytes that cause no event, no new error and carry no tlast give no transfer
// a stall on m_axis holds the result register; s_axis_tready drops once the
// input register also holds a byte
// async active-low reset returns the parser to the start of a message
`include "bencode_stream_tokenizer_assert.svh"

module bencode_stream_tokenizer #(
    parameter int MAX_DEPTH   = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // message_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [63:0] value, [71:64] data_byte,
                                        // [76:72] nesting, [77] string_last,
                                        // [78] value_complete,
                                        // [82:79] error_code, [87:83] zero
    output logic [3:0]  m_axis_tuser,   // [2:0] event_res, [3] is_key
    output logic        m_axis_tlast    // end_flag
);

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_end_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    bst_pkg::bst_result_t out_reg;

    logic                 advance;   // result register free this cycle
    logic                 process;   // parser consumes the held byte
    logic                 in_xfer;
    logic                 emit;
    bst_pkg::bst_result_t res;

    // terms used by the checks below
    logic                 quiet_res;
    logic                 end_res;
    logic                 end_resolved;
    logic                 last_res;
    logic                 last_is_byte;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (process)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = process && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
        if (process && emit)
            out_reg <= res;
    end

    // all per-byte decoding and the container stack
    bst_parser #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (process),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .emit    (emit),
        .res     (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.error_code, out_reg.value_complete,
                            out_reg.string_last, out_reg.nesting,
                            out_reg.data_byte, out_reg.value};
    assign m_axis_tuser  = {out_reg.is_key, out_reg.event_res};
    assign m_axis_tlast  = out_reg.end_flag;

    assign quiet_res    = out_valid_reg && out_reg.event_res == bst_pkg::EV_NONE &&
                          out_reg.error_code == bst_pkg::ERR_OK;
    assign end_res      = out_valid_reg && out_reg.end_flag;
    assign end_resolved = out_reg.value_complete || out_reg.error_code != bst_pkg::ERR_OK;
    assign last_res     = out_valid_reg && out_reg.string_last;
    assign last_is_byte = out_reg.event_res == bst_pkg::EV_STR_BYTE;

    // a result with no event and no fresh error only answers a message end
    `BST_ASSERT_IMPL(a_quiet_result_is_end, clk, rst_n, quiet_res, out_reg.end_flag)
    // at message end either the value is complete or an error is reported
    `BST_ASSERT_IMPL(a_end_is_resolved, clk, rst_n, end_res, end_resolved)
    // only a payload byte can close a string
    `BST_ASSERT_IMPL(a_last_on_string_byte, clk, rst_n, last_res, last_is_byte)
    // a held byte is never dropped while the result side stalls
    `BST_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

FILE: bench/bst_token_checker.sv
// token predictor and result checker for the bencode stream tokenizer
module bst_token_checker
    import bst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STACK_DEPTH = 16;
    localparam logic [63:0] LEN_LIMIT   = 64'h0000_0000_FFFF_FFFF;

    // parser state as the block should hold it
    bst_mode_t   parse_mode;
    logic [63:0] acc;
    logic        neg;
    logic        seen_digit;
    logic [63:0] remaining;
    logic [4:0]  depth;
    logic        is_dict  [STACK_DEPTH];
    logic        want_key [STACK_DEPTH];
    bst_error_t  sticky;
    logic        top_complete;

    bst_result_t token_q[$];

    function automatic void clear_parser();
        parse_mode   = MD_VALUE;
        acc          = '0;
        neg          = 1'b0;
        seen_digit   = 1'b0;
        remaining    = '0;
        depth        = '0;
        sticky       = ERR_OK;
        top_complete = 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            is_dict[k]  = 1'b0;
            want_key[k] = 1'b0;
        end
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic at_key();
        return depth != 0 && is_dict[depth - 5'd1] && want_key[depth - 5'd1];
    endfunction

    function automatic logic mul_overflows(logic [63:0] a, logic [3:0] d, logic [63:0] lim);
        return a > (lim - 64'(d)) / 64'd10;
    endfunction

    // a value has ended: either the whole message or one entry of a container
    function automatic void close_value();
        if (depth == 0)
        begin
            top_complete = 1'b1;
            parse_mode   = MD_DONE;
        end
        else
        begin
            if (is_dict[depth - 5'd1])
                want_key[depth - 5'd1] = !want_key[depth - 5'd1];
            parse_mode = MD_VALUE;
        end
    endfunction

    // advances the parser by one byte; returns 1 when the byte yields a token transfer
    function automatic logic tokenize_byte(input logic [7:0] b, input logic last,
                                           output bst_result_t r);
        bst_event_t  ev;
        bst_error_t  err;
        logic [63:0] val;
        logic [63:0] lim;
        logic [7:0]  db;
        logic        key;
        logic        str_end;
        logic [3:0]  d;
        ev      = EV_NONE;
        err     = ERR_OK;
        val     = '0;
        db      = '0;
        key     = 1'b0;
        str_end = 1'b0;
        d       = 4'(b - CH_ZERO);
        r       = '0;

        if (sticky == ERR_OK && !top_complete)
        begin
            case (parse_mode)
                MD_VALUE:
                begin
                    if (is_digit(b))
                    begin
                        acc        = 64'(d);
                        seen_digit = 1'b1;
                        parse_mode = MD_STR_LEN;
                    end
                    else if (b == CH_E)
                    begin
                        if (depth == 0)
                            err = ERR_STRAY_END;
                        else if (is_dict[depth - 5'd1] && !want_key[depth - 5'd1])
                            err = ERR_NO_VALUE;
                        else
                        begin
                            depth = depth - 5'd1;
                            ev    = EV_CLOSE;
                            close_value();
                        end
                    end
                    else if (at_key())
                        err = (b == CH_I || b == CH_L || b == CH_D) ? ERR_KEY_TYPE
                                                                    : ERR_BAD_TYPE;
                    else if (b == CH_I)
                    begin
                        acc        = '0;
                        neg        = 1'b0;
                        seen_digit = 1'b0;
                        parse_mode = MD_INT_SIGN;
                    end
                    else if (b == CH_L || b == CH_D)
                    begin
                        if (depth >= STACK_DEPTH)
                            err = ERR_TOO_DEEP;
                        else
                        begin
                            is_dict[depth]  = (b == CH_D);
                            want_key[depth] = (b == CH_D);
                            depth           = depth + 5'd1;
                            ev              = (b == CH_D) ? EV_DICT_OPEN : EV_LIST_OPEN;
                        end
                    end
                    else
                        err = ERR_BAD_TYPE;
                end
                MD_INT_SIGN:
                begin
                    if (b == CH_MINUS)
                    begin
                        neg        = 1'b1;
                        parse_mode = MD_INT_DIGITS;
                    end
                    else if (is_digit(b))
                    begin
                        acc        = 64'(d);
                        seen_digit = 1'b1;
                        parse_mode = MD_INT_DIGITS;
                    end
                    else
                        err = ERR_BAD_DIGIT;
                end
                MD_INT_DIGITS:
                begin
                    lim = neg ? INT_NEG_LIMIT[63:0] : INT_POS_LIMIT[63:0];
                    if (is_digit(b))
                    begin
                        // a zero that already stands alone may not be followed
                        if (seen_digit && acc == 0)
                            err = ERR_BAD_DIGIT;
                        else if (mul_overflows(acc, d, lim))
                            err = ERR_OVERFLOW;
                        else
                        begin
                            acc        = acc * 64'd10 + 64'(d);
                            seen_digit = 1'b1;
                        end
                    end
                    else if (b == CH_E)
                    begin
                        if (!seen_digit || (neg && acc == 0))
                            err = ERR_BAD_DIGIT;
                        else
                        begin
                            ev  = EV_INTEGER;
                            val = neg ? 64'd0 - acc : acc;
                            close_value();
                        end
                    end
                    else
                        err = ERR_BAD_DIGIT;
                end
                MD_STR_LEN:
                begin
                    if (is_digit(b))
                    begin
                        if (acc == 0)
                            err = ERR_BAD_DIGIT;
                        else if (mul_overflows(acc, d, LEN_LIMIT))
                            err = ERR_OVERFLOW;
                        else
                            acc = acc * 64'd10 + 64'(d);
                    end
                    else if (b == CH_COLON)
                    begin
                        ev  = EV_STR_START;
                        val = acc;
                        key = at_key();
                        if (acc == 0)
                            close_value();
                        else
                        begin
                            remaining  = acc;
                            parse_mode = MD_STR_DATA;
                        end
                    end
                    else
                        err = ERR_BAD_DIGIT;
                end
                MD_STR_DATA:
                begin
                    ev  = EV_STR_BYTE;
                    db  = b;
                    key = at_key();
                    if (remaining != 0)
                        remaining = remaining - 64'd1;
                    if (remaining == 0)
                    begin
                        str_end = 1'b1;
                        close_value();
                    end
                end
                default:
                begin
                end
            endcase
            if (err != ERR_OK)
                sticky = err;
        end

        if (last && sticky == ERR_OK && !top_complete)
            sticky = ERR_TRUNCATED;

        if (ev == EV_NONE && err == ERR_OK && !last)
            return 1'b0;

        r.event_res      = ev;
        r.value          = val;
        r.data_byte      = db;
        r.nesting        = depth;
        r.is_key         = key;
        r.string_last    = str_end;
        r.value_complete = top_complete;
        r.end_flag       = last;
        r.error_code     = sticky;
        if (last)
            clear_parser();
        return 1'b1;
    endfunction

    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want === got)
            return 0;
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        return 1;
    endfunction

    always @(posedge clk)
    begin
        bst_result_t want;
        bst_result_t fresh;
        int          bad;
        if (!rst_n)
        begin
            clear_parser();
            token_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (token_q.size() == 0)
                begin
                    $error("token transfer with no token expected");
                    mismatches++;
                end
                else
                begin
                    want = token_q.pop_front();
                    bad  = 0;
                    bad += field_differs("event_res", 64'(want.event_res), 64'(m_axis_tuser[2:0]));
                    bad += field_differs("value", want.value, m_axis_tdata[63:0]);
                    bad += field_differs("data_byte", 64'(want.data_byte),
                                         64'(m_axis_tdata[71:64]));
                    bad += field_differs("nesting", 64'(want.nesting), 64'(m_axis_tdata[76:72]));
                    bad += field_differs("is_key", 64'(want.is_key), 64'(m_axis_tuser[3]));
                    bad += field_differs("string_last", 64'(want.string_last),
                                         64'(m_axis_tdata[77]));
                    bad += field_differs("value_complete", 64'(want.value_complete),
                                         64'(m_axis_tdata[78]));
                    bad += field_differs("end_flag", 64'(want.end_flag), 64'(m_axis_tlast));
                    bad += field_differs("error_code", 64'(want.error_code),
                                         64'(m_axis_tdata[82:79]));
                    if (bad != 0)
                        mismatches++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (tokenize_byte(s_axis_tdata, s_axis_tlast, fresh))
                    token_q.insert(token_q.size(), fresh);
            end
        end
        pending = token_q.size();
    end

endmodule

FILE: bench/tb_bencode_stream_tokenizer.sv
// stimulus and verdict for the bencode stream tokenizer
module tb_bencode_stream_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;

    // stimulus stops once this many message bytes went out in the random part
    localparam int RANDOM_BYTES = 1050;
    // generous cycle budget, far above the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    // receiver hold-off used to fill both pipeline registers
    localparam int SQUEEZE_LEN  = 60;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] byte_in
    logic        s_axis_tlast  = 1'b0; // message_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;         // [63:0] value, [71:64] data_byte, [76:72] nesting,
                                       // [77] string_last, [78] value_complete,
                                       // [82:79] error_code
    logic [3:0]  m_axis_tuser;         // [2:0] event_res, [3] is_key
    logic        m_axis_tlast;         // end_flag

    int mismatches;
    int pending;

    // idle rates in percent, switched between phases of the random part
    int   send_idle_pct = 31;
    int   recv_idle_pct = 50;
    logic hold_off      = 1'b0;
    logic squeeze_start = 1'b0;
    int   cycle_count   = 0;

    // message under construction, plus the stack of containers still open in it
    logic [7:0] msg[$];
    logic       open_dict[$];
    int         open_left[$];

    bencode_stream_tokenizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bst_token_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost token ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random back-pressure, or a solid stall while the hold-off runs
    always @(posedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle_pct);

    // one long stall at the start of the no-idle phase so the block backs up
    // and has to drop s_axis_tready while the sender keeps offering bytes
    initial
    begin
        wait (squeeze_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (SQUEEZE_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ---------------------------------------------------------------- message builders

    // append one byte to the message under construction
    function automatic void add_byte(logic [7:0] b);
        msg.insert(msg.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endfunction

    function automatic void add_number(longint unsigned mag);
        logic [7:0] digits[$];
        do
        begin
            digits.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        while (mag != 0);
        foreach (digits[k])
            add_byte(digits[k]);
    endfunction

    // length prefix, colon, then payload bytes over the whole byte range
    function automatic void add_string(int len);
        add_number(longint'(len));
        add_byte(CH_COLON);
        for (int k = 0; k < len; k++)
            add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_int();
        longint unsigned mag;
        logic            negate;
        case ($urandom_range(0, 3))
            0:       mag = $urandom_range(0, 9);
            1:       mag = $urandom_range(0, 99999);
            2:       mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: mag = 64'h7FFF_FFFF_FFFF_FFFF + $urandom_range(0, 1)
                           - $urandom_range(0, 3);
        endcase
        // minus zero is malformed, keep it out of the well-formed stream
        negate = (mag != 0) && ($urandom_range(0, 99) < 40);
        add_byte(CH_I);
        if (negate)
            add_byte(CH_MINUS);
        add_number(mag);
        add_byte(CH_E);
    endfunction

    // one value: a scalar, or the opening byte of a container pushed on the stack
    function automatic void add_value(int max_depth);
        logic dict;
        if (open_dict.size() < max_depth && $urandom_range(0, 99) < 35)
        begin
            dict = $urandom_range(0, 1);
            add_byte(dict ? CH_D : CH_L);
            open_dict.insert(open_dict.size(), dict);
            open_left.insert(open_left.size(), $urandom_range(0, 3));
        end
        else if ($urandom_range(0, 1))
            add_string(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6));
        else
            add_int();
    endfunction

    // well-formed nested value, built without recursion
    function automatic void add_tree(int max_depth);
        int top;
        add_value(max_depth);
        while (open_dict.size() != 0)
        begin
            top = open_left.size() - 1;
            if (open_left[top] == 0)
            begin
                add_byte(CH_E);
                void'(open_dict.pop_back());
                void'(open_left.pop_back());
            end
            else
            begin
                open_left[top] = open_left[top] - 1;
                if (open_dict[top])
                    add_string($urandom_range(0, 4));
                add_value(max_depth);
            end
        end
    endfunction

    // containers nested around the stack limit, some of them dictionary values
    function automatic void add_deep();
        int levels;
        levels = $urandom_range(12, 18);
        for (int k = 0; k < levels; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                add_byte(CH_D);
                add_string($urandom_range(0, 2));
            end
            else
                add_byte(CH_L);
        end
        add_int();
        for (int k = 0; k < levels; k++)
            add_byte(CH_E);
    endfunction

    // short malformed or boundary messages named by the syntax rules
    function automatic string odd_case(int idx);
        case (idx)
            0:       return "i9223372036854775807e";   // largest positive
            1:       return "i-9223372036854775808e";  // most negative
            2:       return "i9223372036854775808e";   // one past positive range
            3:       return "i-9223372036854775809e";  // one past negative range
            4:       return "i123456789012345678901e";
            5:       return "4294967295:ab";           // longest length, cut short
            6:       return "4294967296:";             // length over the limit
            7:       return "99999999999:";
            8:       return "01:a";                    // leading zero in a length
            9:       return "00:";
            10:      return "1x";                      // junk inside a length
            11:      return "i-e";                     // sign with no digits
            12:      return "ie";                      // no digits at all
            13:      return "i1xe";
            14:      return "i+1e";
            15:      return "i007e";                   // leading zeros
            16:      return "i-01e";
            17:      return "dle";                     // list where a key belongs
            18:      return "ddee";
            19:      return "di1e1:ae";
            20:      return "d1:a";                    // key then message end
            21:      return "x";                       // unknown type byte
            22:      return "le";
            23:      return "lli1eee";
            24:      return "3:abc";
            default: return "d3:keyl1:vee";
        endcase
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // whole message, tlast on its final byte
    task automatic send_message();
        for (int k = 0; k < msg.size(); k++)
            send_byte(msg[k], k == msg.size() - 1);
        msg.delete();
    endtask

    initial
    begin
        int random_sent;
        int body;
        int pick;
        int cut;

        random_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed messages
        add_text("e");                          // close with nothing open
        send_message();
        add_text("0:");                         // empty string, then a trailing byte
        add_byte(8'hFF);
        send_message();
        add_text("i-0e");                       // negative zero
        send_message();
        add_text("d1:");                        // key holding a zero byte
        add_byte(8'h00);
        add_text("i1ee");
        send_message();
        add_text("d1:ae");                      // key with no value before the close
        send_message();
        add_text("di");                         // integer in key position
        send_message();
        add_text("l");                          // message ends inside a list
        send_message();

        // random messages: mostly well-formed trees, mixed with deep, boundary and noise
        while (random_sent < RANDOM_BYTES)
        begin
            if (random_sent >= 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                squeeze_start = 1'b1;
            end
            else if (random_sent >= RANDOM_BYTES / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 31;
            end

            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                add_tree($urandom_range(1, 4));
                cut = $urandom_range(0, 99);
                if (cut < 10 && msg.size() > 1)
                begin
                    // truncate the value somewhere inside
                    body = $urandom_range(1, msg.size() - 1);
                    while (msg.size() > body)
                        void'(msg.pop_back());
                end
                else if (cut < 20)
                    msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
                else if (cut < 25)
                    msg.insert($urandom_range(0, msg.size() - 1), 8'($urandom_range(0, 255)));
            end
            else if (pick < 78)
                add_deep();
            else if (pick < 90)
                add_text(odd_case($urandom_range(0, 25)));
            else
            begin
                repeat ($urandom_range(1, 8))
                    add_byte(8'($urandom_range(0, 255)));
            end

            // bytes after the value only get ignored, so they do not count
            random_sent += msg.size();
            if ($urandom_range(0, 99) < 25)
            begin
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom_range(0, 255)));
            end
            send_message();
        end
        s_axis_tvalid <= 1'b0;

        // drain the tokens still owed, then leave room for stray transfers
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: bencode_stream_tokenizer.f
+incdir+design
design/bst_pkg.sv
design/bst_parser.sv
design/bencode_stream_tokenizer.sv
bench/bst_token_checker.sv
bench/tb_bencode_stream_tokenizer.sv
